// File: src/lhsd_pkg.sv
// Shared constants, codes and control structs of the length-header string deframer.
`default_nettype none

package lhsd_pkg;

    // Sizing of the length table and of the per-byte result burst.
    localparam int MAX_STRINGS = 16;
    localparam int LENGTH_BITS = 16;
    localparam int MAX_RESULTS = 16;

    localparam int IDX_W  = $clog2(MAX_STRINGS);
    localparam int CNT_W  = $clog2(MAX_STRINGS + 1);
    localparam int RES_W  = $clog2(MAX_RESULTS + 1);
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int SIDX_W = 4;

    // Header delimiters and the digit range.
    localparam logic [BYTE_W-1:0] CHAR_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

    // Result kinds as they appear on the output channel.
    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE       = 2'd0,
        KIND_EMPTY_STR  = 2'd1,
        KIND_EMPTY_LIST = 2'd2,
        KIND_ERROR      = 2'd3
    } kind_t;

    // Outcome of a header byte, decided at the cycle the item is accepted.
    typedef enum logic [1:0] {
        HDR_NONE,
        HDR_ERROR,
        HDR_EMPTY_LIST,
        HDR_FLUSH
    } hdr_res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  accept;
        logic  load;
        kind_t kind;
        logic  last;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        hdr_res_t hdr_res;
        logic     in_payload;
        logic     rem_zero;
        logic     rem_one;
        logic     next_done;
        logic     next_rem_zero;
        logic     slot_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: src/lhsd_ifs.sv
// Valid/ready channel interfaces for the byte stream and the result stream.
`default_nettype none

interface lhsd_stream_if;
    logic                        valid;
    logic                        ready;
    logic [lhsd_pkg::BYTE_W-1:0] data_byte;
    logic                        start_of_message;

    modport source (output valid, output data_byte, output start_of_message, input ready);
    modport sink (input valid, input data_byte, input start_of_message, output ready);
endinterface

interface lhsd_result_if;
    logic                        valid;
    logic                        ready;
    logic [lhsd_pkg::KIND_W-1:0] out_kind;
    logic [lhsd_pkg::BYTE_W-1:0] out_byte;
    logic [lhsd_pkg::SIDX_W-1:0] string_index;
    logic                        last_of_string;
    logic                        last_of_message;
    logic                        last;

    modport source (
        output valid, output out_kind, output out_byte, output string_index,
        output last_of_string, output last_of_message, output last, input ready
    );
    modport sink (
        input valid, input out_kind, input out_byte, input string_index,
        input last_of_string, input last_of_message, input last, output ready
    );
endinterface

`default_nettype wire

// File: src/lhsd_datapath.sv
// Parser state, length table and output register of the deframer.
`default_nettype none

module lhsd_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [lhsd_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                        start_of_message,
    input  wire logic                        out_ready,
    input  wire lhsd_pkg::dp_cmd_t           cmd,
    output lhsd_pkg::dp_status_t             status,
    output logic                             out_valid,
    output logic [lhsd_pkg::KIND_W-1:0]      out_kind,
    output logic [lhsd_pkg::BYTE_W-1:0]      out_byte,
    output logic [lhsd_pkg::SIDX_W-1:0]      string_index,
    output logic                             last_of_string,
    output logic                             last_of_message,
    output logic                             last
);

    localparam int LB     = lhsd_pkg::LENGTH_BITS;
    localparam int PROD_W = lhsd_pkg::LENGTH_BITS + 4;
    localparam int CW     = lhsd_pkg::CNT_W;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_WAIT
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [LB-1:0]               acc_reg, acc_next;
    logic                        digit_reg, digit_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               cur_reg, cur_next;
    logic [LB-1:0]               rem_reg, rem_next;
    logic [lhsd_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic [LB-1:0]               len_table [lhsd_pkg::MAX_STRINGS];

    logic                        out_valid_reg, out_valid_next;
    lhsd_pkg::kind_t             out_kind_reg;
    logic [lhsd_pkg::BYTE_W-1:0] out_byte_reg;
    logic [lhsd_pkg::SIDX_W-1:0] out_idx_reg;
    logic                        out_los_reg;
    logic                        out_lom_reg;
    logic                        out_last_reg;

    phase_t                      eff_phase;
    logic [LB-1:0]               eff_acc;
    logic                        eff_digit;
    logic [CW-1:0]               eff_count;
    logic                        is_digit;
    logic                        is_comma;
    logic                        is_hash;
    logic [PROD_W-1:0]           acc_ext;
    logic [PROD_W-1:0]           acc_prod;
    logic                        acc_ovf;
    lhsd_pkg::hdr_res_t          hdr_res;
    logic [CW-1:0]               next_idx;
    logic                        next_done;
    logic [LB-1:0]               next_rem;
    logic                        rem_one;
    logic                        tbl_we;
    logic                        advance;

    // The start flag clears the parser ahead of the byte that carries it.
    always_comb
    begin
        eff_phase = start_of_message ? PH_HEADER : phase_reg;
        eff_acc   = start_of_message ? '0 : acc_reg;
        eff_digit = start_of_message ? 1'b0 : digit_reg;
        eff_count = start_of_message ? '0 : count_reg;
    end

    // Classify the byte and build the next decimal value (times ten by shifts).
    always_comb
    begin
        is_digit = data_byte inside {[lhsd_pkg::CHAR_ZERO:lhsd_pkg::CHAR_NINE]};
        is_comma = (data_byte == lhsd_pkg::CHAR_COMMA);
        is_hash  = (data_byte == lhsd_pkg::CHAR_HASH);
        acc_ext  = {4'b0000, eff_acc};
        acc_prod = (acc_ext << 3) + (acc_ext << 1) + PROD_W'(data_byte[3:0]);
        acc_ovf  = |acc_prod[PROD_W-1:LB];
    end

    // Header decision for the byte at the input.
    always_comb
    begin
        hdr_res = lhsd_pkg::HDR_NONE;
        if (eff_phase == PH_HEADER)
        begin
            if (is_digit)
            begin
                if (acc_ovf)
                    hdr_res = lhsd_pkg::HDR_ERROR;
            end
            else if (is_comma)
            begin
                if (!eff_digit || (eff_count >= CW'(lhsd_pkg::MAX_STRINGS)))
                    hdr_res = lhsd_pkg::HDR_ERROR;
            end
            else if (is_hash)
            begin
                if (eff_digit)
                    hdr_res = lhsd_pkg::HDR_ERROR;
                else if (eff_count == '0)
                    hdr_res = lhsd_pkg::HDR_EMPTY_LIST;
                else if (len_table[0] == '0)
                    hdr_res = lhsd_pkg::HDR_FLUSH;
            end
            else
            begin
                hdr_res = lhsd_pkg::HDR_ERROR;
            end
        end
    end

    // Look ahead to the string after the current one.
    always_comb
    begin
        next_idx  = cur_reg + 1'b1;
        next_done = (next_idx >= count_reg);
        next_rem  = len_table[next_idx[lhsd_pkg::IDX_W-1:0]];
        rem_one   = (rem_reg == LB'(1));
    end

    always_comb
    begin
        status.hdr_res       = hdr_res;
        status.in_payload    = !start_of_message && (phase_reg == PH_PAYLOAD);
        status.rem_zero      = (rem_reg == '0);
        status.rem_one       = rem_one;
        status.next_done     = next_done;
        status.next_rem_zero = (next_rem == '0);
        status.slot_free     = !out_valid_reg || out_ready;
    end

    // Parser state update on an accepted item or an emitted result.
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        digit_next = digit_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        rem_next   = rem_reg;
        byte_next  = byte_reg;
        tbl_we     = 1'b0;
        advance    = 1'b0;

        if (cmd.accept)
        begin
            byte_next = data_byte;
            if (start_of_message)
            begin
                phase_next = PH_HEADER;
                acc_next   = '0;
                digit_next = 1'b0;
                count_next = '0;
                cur_next   = '0;
                rem_next   = '0;
            end
            if (eff_phase == PH_HEADER)
            begin
                case (hdr_res)
                    lhsd_pkg::HDR_ERROR,
                    lhsd_pkg::HDR_EMPTY_LIST:
                    begin
                        phase_next = PH_WAIT;
                    end
                    default:
                    begin
                        if (is_digit)
                        begin
                            acc_next   = acc_prod[LB-1:0];
                            digit_next = 1'b1;
                        end
                        else if (is_comma)
                        begin
                            tbl_we     = 1'b1;
                            count_next = eff_count + 1'b1;
                            acc_next   = '0;
                            digit_next = 1'b0;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                            cur_next   = '0;
                            rem_next   = len_table[0];
                        end
                    end
                endcase
            end
        end
        else if (cmd.load)
        begin
            case (cmd.kind)
                lhsd_pkg::KIND_EMPTY_STR:
                begin
                    advance = 1'b1;
                end
                lhsd_pkg::KIND_BYTE:
                begin
                    rem_next = rem_reg - 1'b1;
                    advance  = rem_one;
                end
                default:
                begin
                    advance = 1'b0;
                end
            endcase
        end

        // Step to the next string, or close the message after the last one.
        if (advance)
        begin
            cur_next = next_idx;
            if (next_done)
                phase_next = PH_WAIT;
            else
                rem_next = next_rem;
        end
    end

    // Output register handshake.
    always_comb
    begin
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            acc_reg       <= '0;
            digit_reg     <= 1'b0;
            count_reg     <= '0;
            cur_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            digit_reg     <= digit_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Length table and stored payload byte.
    always_ff @(posedge clk)
    begin
        if (tbl_we)
            len_table[eff_count[lhsd_pkg::IDX_W-1:0]] <= eff_acc;
        byte_reg <= byte_next;
    end

    // Result fields, formed as the result is loaded.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_kind_reg <= cmd.kind;
            out_last_reg <= cmd.last;
            case (cmd.kind)
                lhsd_pkg::KIND_BYTE:
                begin
                    out_byte_reg <= byte_reg;
                    out_idx_reg  <= cur_reg[lhsd_pkg::SIDX_W-1:0];
                    out_los_reg  <= rem_one;
                    out_lom_reg  <= rem_one && next_done;
                end
                lhsd_pkg::KIND_EMPTY_STR:
                begin
                    out_byte_reg <= '0;
                    out_idx_reg  <= cur_reg[lhsd_pkg::SIDX_W-1:0];
                    out_los_reg  <= 1'b1;
                    out_lom_reg  <= next_done;
                end
                default:
                begin
                    out_byte_reg <= '0;
                    out_idx_reg  <= '0;
                    out_los_reg  <= 1'b0;
                    out_lom_reg  <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_kind        = out_kind_reg;
    assign out_byte        = out_byte_reg;
    assign string_index    = out_idx_reg;
    assign last_of_string  = out_los_reg;
    assign last_of_message = out_lom_reg;
    assign last            = out_last_reg;

endmodule

`default_nettype wire

// File: src/lhsd_ctrl.sv
// Controller that sequences the results caused by each accepted byte.
`default_nettype none

module lhsd_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire lhsd_pkg::dp_status_t status,
    output lhsd_pkg::dp_cmd_t         cmd
);

    localparam int RW = lhsd_pkg::RES_W;
    localparam logic [RW-1:0] CAP_A = RW'(lhsd_pkg::MAX_RESULTS - 1);
    localparam logic [RW-1:0] CAP_B = RW'(lhsd_pkg::MAX_RESULTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERROR,
        ST_LIST,
        ST_FLUSH_A,
        ST_BYTE,
        ST_FLUSH_B
    } state_t;

    state_t        state_reg, state_next;
    logic [RW-1:0] n_reg, n_next;
    logic [RW-1:0] n_inc;
    logic [RW-1:0] cap;

    // Next state and commands. FLUSH_A runs the zero-length markers ahead of a
    // payload byte, FLUSH_B those after it or after the header end.
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        n_inc      = n_reg + 1'b1;
        cap        = (state_reg == ST_FLUSH_A) ? CAP_A : CAP_B;
        in_ready   = (state_reg == ST_IDLE);
        cmd.accept = 1'b0;
        cmd.load   = 1'b0;
        cmd.kind   = lhsd_pkg::KIND_BYTE;
        cmd.last   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    n_next     = '0;
                    case (status.hdr_res)
                        lhsd_pkg::HDR_ERROR:      state_next = ST_ERROR;
                        lhsd_pkg::HDR_EMPTY_LIST: state_next = ST_LIST;
                        lhsd_pkg::HDR_FLUSH:      state_next = ST_FLUSH_B;
                        default:
                        begin
                            if (status.in_payload)
                                state_next = status.rem_zero ? ST_FLUSH_A : ST_BYTE;
                        end
                    endcase
                end
            end

            ST_ERROR,
            ST_LIST:
            begin
                if (status.slot_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.kind   = (state_reg == ST_ERROR) ? lhsd_pkg::KIND_ERROR
                                                         : lhsd_pkg::KIND_EMPTY_LIST;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_FLUSH_A,
            ST_FLUSH_B:
            begin
                if (status.slot_free)
                begin
                    cmd.load = 1'b1;
                    cmd.kind = lhsd_pkg::KIND_EMPTY_STR;
                    n_next   = n_inc;
                    if (status.next_done)
                    begin
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (status.next_rem_zero)
                    begin
                        if (n_inc >= cap)
                        begin
                            cmd.last   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else if (state_reg == ST_FLUSH_A)
                    begin
                        state_next = ST_BYTE;
                    end
                    else
                    begin
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_BYTE:
            begin
                if (status.slot_free)
                begin
                    cmd.load = 1'b1;
                    cmd.kind = lhsd_pkg::KIND_BYTE;
                    n_next   = n_inc;
                    if (status.rem_one && !status.next_done && status.next_rem_zero
                        && (n_inc < CAP_B))
                    begin
                        state_next = ST_FLUSH_B;
                    end
                    else
                    begin
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
        end
    end

endmodule

`default_nettype wire

// File: src/length_header_string_deframer_core.sv
// Top level of the length-header string deframer.
// The block takes a message one byte per item: a header of decimal lengths,
// each closed by ',', ended by '#', then the payload bytes, which come out
// tagged with their string index and end-of-string and end-of-message flags.
// Zero-length strings and an empty list give marker results, and a malformed
// header gives one error result, after which bytes are ignored until an item
// with start_of_message set. Header bytes that cause no result leave the
// controller idle. A byte that causes results is accepted, and then the
// controller emits one result a cycle while the output slot is free, into a
// single output register; the next byte is accepted after the last result
// has gone into that register, even while it still waits to be taken.
`default_nettype none

module length_header_string_deframer_core (
    input wire logic     clk,
    input wire logic     rst_n,
    lhsd_stream_if.sink  stream,
    lhsd_result_if.source result
);

    lhsd_pkg::dp_cmd_t    cmd;
    lhsd_pkg::dp_status_t status;

    // Sequencing of results per byte.
    lhsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stream.valid),
        .in_ready (stream.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Parser state, length table and output register.
    lhsd_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .data_byte        (stream.data_byte),
        .start_of_message (stream.start_of_message),
        .out_ready        (result.ready),
        .cmd              (cmd),
        .status           (status),
        .out_valid        (result.valid),
        .out_kind         (result.out_kind),
        .out_byte         (result.out_byte),
        .string_index     (result.string_index),
        .last_of_string   (result.last_of_string),
        .last_of_message  (result.last_of_message),
        .last             (result.last)
    );

endmodule

`default_nettype wire
